### rtl/core/mfbso_pkg.sv
// mfbso_pkg: constants, codes and types for the monochrome framebuffer scanout
// no dependencies; used by mfbso_if, mfbso_scan and mono_framebuffer_scanout_2x
`default_nettype none

package mfbso_pkg;

	localparam int COLUMNS      = 128;
	localparam int ACTIVE_LINES = 54;
	localparam int SCAN_LINES   = 2 * ACTIVE_LINES;

	localparam int COLOR_W = 16;
	localparam int ADDR_W  = 10;
	localparam int DATA_W  = 8;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int LINE_W = $clog2(SCAN_LINES);
	localparam int PAGE_W = (LINE_W > 4) ? LINE_W - 4 : 1;
	localparam int PROD_W = COL_W + PAGE_W + 1;
	localparam int BIT_W  = 3;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COLOR_W;

	localparam logic [CFG_IDX_W-1:0] REG_INK   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAPER = 1'd1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [COLOR_W-1:0] INK_RESET   = 16'h0000;
	localparam logic [COLOR_W-1:0] PAPER_RESET = 16'hFFFF;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BIT_W-1:0]  bitpos;
		logic              done;
	} scan_t;

endpackage

`default_nettype wire

### rtl/core/mfbso_if.sv
// mfbso_cmd_if and mfbso_pix_if: valid/ready channels of the scanout block
// depends on mfbso_pkg
`default_nettype none

interface mfbso_cmd_if;
	import mfbso_pkg::*;
	logic                valid;
	logic                ready;
	logic                operation;
	logic [ADDR_W-1:0]   write_address;
	logic [DATA_W-1:0]   write_data;
	modport source (output valid, operation, write_address, write_data, input ready);
	modport sink (input valid, operation, write_address, write_data, output ready);
endinterface

interface mfbso_pix_if;
	import mfbso_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] pixel_color;
	logic               last_of_run;
	logic               frame_done;
	modport source (output valid, pixel_color, last_of_run, frame_done, input ready);
	modport sink (input valid, pixel_color, last_of_run, frame_done, output ready);
endinterface

`default_nettype wire

### rtl/core/mfbso_ram.sv
// mfbso_ram: simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module mfbso_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/mfbso_scan.sv
// mfbso_scan: bottom-to-top, right-to-left scan position and its byte address
// depends on mfbso_pkg
`default_nettype none

module mfbso_scan (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	output mfbso_pkg::scan_t     pos
);
	import mfbso_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [LINE_W-1:0] line_q;
	logic [PAGE_W-1:0] page;
	logic [PROD_W-1:0] base;
	logic [PROD_W-1:0] sum;

	// zero-based: column 0 and line 0 are the last of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= COL_W'(COLUMNS - 1);
			line_q <= LINE_W'(SCAN_LINES - 1);
		end else if (step) begin
			if (col_q == '0) begin
				col_q <= COL_W'(COLUMNS - 1);
				if (line_q == '0) begin
					line_q <= LINE_W'(SCAN_LINES - 1);
				end else begin
					line_q <= line_q - 1'b1;
				end
			end else begin
				col_q <= col_q - 1'b1;
			end
		end
	end

	assign page = PAGE_W'(line_q >> 4);
	assign base = PROD_W'(COLUMNS) * PROD_W'(page);
	assign sum  = base + PROD_W'(col_q);

	assign pos.addr   = ADDR_W'(sum);
	assign pos.bitpos = line_q[BIT_W:1];
	assign pos.done   = (col_q == '0) && (line_q == '0);

endmodule

`default_nettype wire

### rtl/core/mono_framebuffer_scanout_2x.sv
// mono_framebuffer_scanout_2x: 1 bpp page framebuffer with 2x rgb565 scanout
// depends on mfbso_pkg, mfbso_if, mfbso_ram, mfbso_scan
//
// A write item stores one byte (eight vertical pixels, bit 0 on top). A tick
// item reads the next source pixel from the ram (registered read) and sends
// it as two transfers on the pixel channel, first with last_of_run low, then
// high; frame_done marks the second transfer of the last pixel of a frame.
// The pixel output register sends one transfer per cycle while pix.ready is
// high. The command channel is held off while the second pixel of a tick is
// pending, so no new item is taken until that pixel is loaded. The scan
// runs right to left within a line and bottom to top, each source row twice.
// Colors come from the ink and paper registers, written through cfg_we.
`default_nettype none

module mono_framebuffer_scanout_2x (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	mfbso_cmd_if.sink                              cmd,
	mfbso_pix_if.source                            pix,
	input  wire logic                              cfg_we,
	input  wire logic [mfbso_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mfbso_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mfbso_pkg::*;

	logic [COLOR_W-1:0] ink_q;
	logic [COLOR_W-1:0] paper_q;

	logic               cmd_xfer;
	logic               tick_xfer;
	logic               write_xfer;
	scan_t              pos;
	logic [DATA_W-1:0]  rd_data;

	logic               tick_v_s1;
	logic               phase_s1;
	logic [BIT_W-1:0]   bitpos_s1;
	logic               done_s1;

	logic               pix_v_s2;
	logic [COLOR_W-1:0] color_s2;
	logic               last_s2;
	logic               frame_done_s2;

	logic               load_s2;
	logic               free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink_q   <= INK_RESET;
			paper_q <= PAPER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INK:   ink_q   <= cfg_data;
				REG_PAPER: paper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign load_s2    = tick_v_s1 && (!pix_v_s2 || pix.ready);
	assign free_s1    = load_s2 && phase_s1;
	assign cmd.ready  = !tick_v_s1 || free_s1;
	assign cmd_xfer   = cmd.valid && cmd.ready;
	assign tick_xfer  = cmd_xfer && (cmd.operation == OP_TICK);
	assign write_xfer = cmd_xfer && (cmd.operation == OP_WRITE);

	mfbso_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (tick_xfer),
		.pos    (pos)
	);

	mfbso_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (write_xfer),
		.waddr (cmd.write_address),
		.wdata (cmd.write_data),
		.re    (tick_xfer),
		.raddr (pos.addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_v_s1 <= 1'b0;
			phase_s1  <= 1'b0;
		end else begin
			if (tick_xfer) begin
				tick_v_s1 <= 1'b1;
				phase_s1  <= 1'b0;
			end else if (free_s1) begin
				tick_v_s1 <= 1'b0;
				phase_s1  <= 1'b0;
			end else if (load_s2) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_xfer) begin
			bitpos_s1 <= pos.bitpos;
			done_s1   <= pos.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_v_s2 <= 1'b0;
		end else if (load_s2) begin
			pix_v_s2 <= 1'b1;
		end else if (pix.ready) begin
			pix_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			color_s2      <= rd_data[bitpos_s1] ? ink_q : paper_q;
			last_s2       <= phase_s1;
			frame_done_s2 <= phase_s1 && done_s1;
		end
	end

	assign pix.valid       = pix_v_s2;
	assign pix.pixel_color = color_s2;
	assign pix.last_of_run = last_s2;
	assign pix.frame_done  = frame_done_s2;

`ifndef ASSERT_OFF
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready && !pix.last_of_run |=> pix.valid && pix.last_of_run)
		else $error("second pixel of a run did not follow the first");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.frame_done |-> pix.last_of_run)
		else $error("frame_done on a first pixel");

	a_tick_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer |=> tick_v_s1 && !phase_s1)
		else $error("tick transfer not held in stage 1");
`endif

endmodule

`default_nettype wire
